[rtl/ole_pkg.sv]
// Package for the ordered list engine.
// Holds the transaction structs, the action and status codes and the default sizes.
// Depends on nothing; every other file imports it.
package ole_pkg;

	localparam int OLE_DEPTH      = 16;
	localparam int OLE_VALUE_BITS = 32;

	typedef enum logic [2:0] {
		ACT_APPEND = 3'd0,
		ACT_SEARCH = 3'd1,
		ACT_GET    = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_START  = 3'd4,
		ACT_NEXT   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_END  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] item_value;
		logic [7:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] result_value;
		logic [3:0]         found_position;
		logic [4:0]         entry_count;
	} rsp_t;

	typedef struct packed {
		logic append;
		logic remove;
	} cell_cmd_t;

endpackage

[rtl/ole_cell.sv]
// One list entry of the cell chain: holds a value, compares it with the key
// and takes its right neighbor's value when it or an entry ahead of it is removed.
// Depends on ole_pkg.
module ole_cell import ole_pkg::*; #(
	parameter int VALUE_BITS = OLE_VALUE_BITS,
	parameter int CNT_W      = 5,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [CNT_W-1:0]      count,
	input  logic [CNT_W-1:0]      pos,
	input  logic [VALUE_BITS-1:0] key,
	input  logic [VALUE_BITS-1:0] next_value,
	output logic [VALUE_BITS-1:0] value,
	output logic                  hit
);

	localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] NXT_IDX = CNT_W'(IDX + 1);

	logic [VALUE_BITS-1:0] value_q;

	always_ff @(posedge clk) begin
		if (cmd.append && (MY_IDX == count)) begin
			value_q <= key;
		end else if (cmd.remove && (MY_IDX >= pos) && (NXT_IDX < count)) begin
			value_q <= next_value;
		end
	end

	assign value = value_q;
	assign hit   = (MY_IDX < count) && (value_q == key);

endmodule

[rtl/ole_ctrl.sv]
// Control for the ordered list engine: count, cursor, action decode,
// read select, first-match encoder and the registered result stage.
// Depends on ole_pkg.
module ole_ctrl import ole_pkg::*; #(
	parameter int DEPTH      = OLE_DEPTH,
	parameter int VALUE_BITS = OLE_VALUE_BITS,
	parameter int CNT_W      = $clog2(DEPTH + 1),
	parameter int IDX_W      = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  req_t                             req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output rsp_t                             rsp,
	input  logic [DEPTH-1:0][VALUE_BITS-1:0] values,
	input  logic [DEPTH-1:0]                 hits,
	output cell_cmd_t                        cell_cmd,
	output logic [CNT_W-1:0]                 count,
	output logic [CNT_W-1:0]                 cell_pos,
	output logic [VALUE_BITS-1:0]            key
);

	localparam int PW = (CNT_W > 8) ? CNT_W : 8;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0]      count_q, count_d;
	logic [CNT_W-1:0]      cursor_q, cursor_d;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q, rsp_d;
	cell_cmd_t             cmd_d;
	logic                  acc;
	logic [PW-1:0]         pos_w;
	logic                  pos_ok;
	logic [IDX_W-1:0]      rd_idx;
	logic [VALUE_BITS-1:0] rd_val;
	logic [IDX_W-1:0]      hit_idx;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign acc       = req_valid && !req_stall;
	assign pos_w     = PW'(req.position);
	assign pos_ok    = pos_w < PW'(count_q);
	assign rd_idx    = (req.action == ACT_NEXT) ? cursor_q[IDX_W-1:0] : pos_w[IDX_W-1:0];
	assign rd_val    = values[rd_idx];
	assign key       = VALUE_BITS'($unsigned(req.item_value));
	assign count     = count_q;
	assign cell_pos  = pos_w[CNT_W-1:0];
	assign cell_cmd  = acc ? cmd_d : '0;

	always_comb begin
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hits[i]) begin
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		cmd_d    = '0;
		count_d  = count_q;
		cursor_d = cursor_q;
		rsp_d    = '0;
		rsp_d.status = ST_OK;
		case (req.action)
			ACT_APPEND: begin
				if (count_q == FULL_CNT) begin
					rsp_d.status = ST_FULL;
				end else begin
					cmd_d.append = 1'b1;
					count_d      = count_q + 1'b1;
				end
			end
			ACT_SEARCH: begin
				if (|hits) begin
					rsp_d.found_position = 4'(hit_idx);
				end else begin
					rsp_d.status = ST_MISS;
				end
			end
			ACT_GET: begin
				if (pos_ok) begin
					rsp_d.result_value = 32'(rd_val);
				end else begin
					rsp_d.status = ST_MISS;
				end
			end
			ACT_REMOVE: begin
				if (pos_ok) begin
					rsp_d.result_value = 32'(rd_val);
					cmd_d.remove       = 1'b1;
					count_d            = count_q - 1'b1;
					if (pos_w < PW'(cursor_q)) begin
						cursor_d = cursor_q - 1'b1;
					end
				end else begin
					rsp_d.status = ST_MISS;
				end
			end
			ACT_START: begin
				cursor_d = '0;
			end
			ACT_NEXT: begin
				if (cursor_q < count_q) begin
					rsp_d.result_value = 32'(rd_val);
					cursor_d           = cursor_q + 1'b1;
				end else begin
					rsp_d.status = ST_END;
				end
			end
			default: begin
			end
		endcase
		rsp_d.entry_count = 5'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cursor_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else if (acc) begin
			count_q     <= count_d;
			cursor_q    <= cursor_d;
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cursor_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("Cursor is past the end of the list.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("Entry count exceeds the depth.");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.action == ACT_APPEND) && (count_q != FULL_CNT))
		|=> (count_q == $past(count_q) + 1'b1))
		else $error("Append did not grow the list.");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid_q)
		else $error("Request stalled with an empty result register.");

endmodule

[rtl/ordered_list_engine.sv]
// Top level of the ordered list engine: a chain of entry cells and its control.
// Depends on ole_pkg, ole_cell and ole_ctrl.
//
//   Channel | Signals                         | Payload
//   --------+---------------------------------+----------------------------------
//   request | req_valid, req_stall, req       | action, item_value, position
//   result  | rsp_valid, rsp_stall, rsp       | status, result_value, found_position,
//           |                                 | entry_count
//
// A transaction may be accepted in every cycle unless a stalled result holds the request side.
// The cycle is set by the key compare in all cells and the first-match encoder.
// The result appears in the result register the cycle after acceptance.
// Reset empties the list and rewinds the cursor; stored values are not cleared.
// A stalled result holds the request side only while the result register is full.
module ordered_list_engine import ole_pkg::*; #(
	parameter int DEPTH      = OLE_DEPTH,
	parameter int VALUE_BITS = OLE_VALUE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	logic [DEPTH-1:0][VALUE_BITS-1:0] values;
	logic [DEPTH-1:0]                 hits;
	cell_cmd_t                        cell_cmd;
	logic [CNT_W-1:0]                 count;
	logic [CNT_W-1:0]                 cell_pos;
	logic [VALUE_BITS-1:0]            key;

	ole_ctrl #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.CNT_W      (CNT_W),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.values    (values),
		.hits      (hits),
		.cell_cmd  (cell_cmd),
		.count     (count),
		.cell_pos  (cell_pos),
		.key       (key)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_BITS-1:0] next_value;

		if (i == DEPTH - 1) begin : g_last
			assign next_value = '0;
		end else begin : g_mid
			assign next_value = values[i+1];
		end

		ole_cell #(
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.count      (count),
			.pos        (cell_pos),
			.key        (key),
			.next_value (next_value),
			.value      (values[i]),
			.hit        (hits[i])
		);
	end

endmodule

[tb/tb_top.sv]
// Testbench for the ordered list engine: a scripted walk through the list actions, then random
// transactions with random idling on both sides, results checked against script or list model.
// Depends on ole_pkg and ordered_list_engine.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ole_pkg::*;

	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam int RANDOM_ITEMS = 700;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_WAIT     = 13;
	localparam int CHOKE_CYCLES = 200;

	typedef struct packed {
		logic [2:0]  act;
		logic [31:0] val;
		logic [7:0]  pos;
		logic [4:0]  reps;
		logic        typed;
		rsp_t        want;
	} script_row_t;

	localparam script_row_t SCRIPT [19] = '{
		'{ACT_NEXT,   32'h00000000, 8'd0,   5'd1,  1'b1, '{ST_END,  32'h0, 4'd0, 5'd0}},
		'{ACT_REMOVE, 32'h00000000, 8'd255, 5'd1,  1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd0}},
		'{ACT_SEARCH, 32'h00000000, 8'd0,   5'd1,  1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd0}},
		'{ACT_APPEND, 32'h80000000, 8'd0,   5'd1,  1'b1, '{ST_OK,   32'h0, 4'd0, 5'd1}},
		'{ACT_APPEND, 32'h7FFFFFFF, 8'd0,   5'd1,  1'b1, '{ST_OK,   32'h0, 4'd0, 5'd2}},
		'{ACT_NEXT,   32'h00000000, 8'd0,   5'd2,  1'b0, '0},
		'{ACT_NEXT,   32'h00000000, 8'd0,   5'd1,  1'b1, '{ST_END,  32'h0, 4'd0, 5'd2}},
		'{ACT_APPEND, 32'hFFFFFFFF, 8'd0,   5'd14, 1'b0, '0},
		'{ACT_APPEND, 32'h00000000, 8'd0,   5'd1,  1'b1, '{ST_FULL, 32'h0, 4'd0, 5'd16}},
		'{ACT_NEXT,   32'h00000000, 8'd0,   5'd1,  1'b0, '0},
		'{ACT_GET,    32'h00000000, 8'd16,  5'd1,  1'b1, '{ST_MISS, 32'h0, 4'd0, 5'd16}},
		'{ACT_SEARCH, 32'h7FFFFFFF, 8'd0,   5'd1,  1'b1, '{ST_OK,   32'h0, 4'd1, 5'd16}},
		'{ACT_REMOVE, 32'h00000000, 8'd0,   5'd1,  1'b1,
			'{ST_OK, 32'h80000000, 4'd0, 5'd15}},
		'{ACT_REMOVE, 32'h00000000, 8'd2,   5'd1,  1'b0, '0},
		'{ACT_NEXT,   32'h00000000, 8'd0,   5'd1,  1'b0, '0},
		'{ACT_SPARE6, 32'h5A5A5A5A, 8'hA5,  5'd1,  1'b0, '0},
		'{ACT_SPARE7, 32'hA5A5A5A5, 8'h5A,  5'd1,  1'b0, '0},
		'{ACT_START,  32'h00000000, 8'd0,   5'd1,  1'b0, '0},
		'{ACT_GET,    32'h00000000, 8'd0,   5'd1,  1'b0, '0}
	};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	req_t req       = '0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	logic signed [31:0] list_mem [OLE_DEPTH];
	logic [4:0] list_len = '0;
	logic [4:0] walk_pos = '0;
	rsp_t due_results [$];

	int mismatch_count = 0;
	int cycle_count    = 0;
	int tx_burst_left  = 0;
	int rx_burst_left  = 0;
	bit choke_pending  = 1'b0;

	ordered_list_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic note_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("mismatch in %s at cycle %0d: got %h, expected %h", field, cycle_count,
			got, want);
	endtask

	task automatic model_action(input req_t r, output rsp_t o);
		o = '0;
		o.status = ST_OK;
		case (r.action)
			ACT_APPEND: begin
				if (list_len == OLE_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					list_mem[list_len[3:0]] = r.item_value;
					list_len = list_len + 1'b1;
				end
			end
			ACT_SEARCH: begin
				o.status = ST_MISS;
				for (int k = 0; k < list_len; k++) begin
					if (o.status == ST_MISS && list_mem[k] == r.item_value) begin
						o.status = ST_OK;
						o.found_position = k[3:0];
					end
				end
			end
			ACT_GET: begin
				if (r.position < list_len) begin
					o.result_value = list_mem[r.position[3:0]];
				end else begin
					o.status = ST_MISS;
				end
			end
			ACT_REMOVE: begin
				if (r.position < list_len) begin
					o.result_value = list_mem[r.position[3:0]];
					for (int k = r.position; k + 1 < list_len; k++) begin
						list_mem[k] = list_mem[k + 1];
					end
					list_len = list_len - 1'b1;
					if (r.position < walk_pos) begin
						walk_pos = walk_pos - 1'b1;
					end
				end else begin
					o.status = ST_MISS;
				end
			end
			ACT_START: begin
				walk_pos = '0;
			end
			ACT_NEXT: begin
				if (walk_pos < list_len) begin
					o.result_value = list_mem[walk_pos[3:0]];
					walk_pos = walk_pos + 1'b1;
				end else begin
					o.status = ST_END;
				end
			end
			default: begin
			end
		endcase
		o.entry_count = list_len;
	endtask

	function automatic req_t draw_action();
		req_t r;
		int pick;
		r = '0;
		case ($urandom_range(0, 3))
			0: r.item_value = $urandom;
			1: r.item_value = $urandom_range(0, 7) - 4;
			2: r.item_value = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			default: r.item_value = (list_len > 0) ?
				list_mem[4'($urandom_range(0, list_len - 1))] : $urandom;
		endcase
		if ($urandom_range(0, 4) == 0) begin
			r.position = 8'($urandom_range(0, 255));
		end else begin
			r.position = 8'($urandom_range(0, list_len));
		end
		pick = $urandom_range(0, 99);
		if ((list_len < 3 && pick < 50) || pick < 25) begin
			r.action = ACT_APPEND;
		end else if (pick < 40) begin
			r.action = ACT_SEARCH;
		end else if (pick < 55) begin
			r.action = ACT_GET;
		end else if (pick < 70) begin
			r.action = ACT_REMOVE;
		end else if (pick < 76) begin
			r.action = ACT_START;
		end else if (pick < 95) begin
			r.action = ACT_NEXT;
		end else begin
			r.action = pick[0] ? ACT_SPARE6 : ACT_SPARE7;
		end
		return r;
	endfunction

	task automatic offer(input req_t r, input logic typed, input rsp_t want);
		rsp_t predicted;
		int gap;
		if (tx_burst_left > 0) begin
			tx_burst_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, MAX_WAIT);
			if ($urandom_range(0, 39) == 0) begin
				tx_burst_left = 30;
			end
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall !== 1'b0);
		model_action(r, predicted);
		due_results.push_back(typed ? want : predicted);
	endtask

	initial begin : request_side
		req_t step;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (SCRIPT[i]) begin
			for (int k = 0; k < SCRIPT[i].reps; k++) begin
				step.action     = SCRIPT[i].act;
				step.item_value = SCRIPT[i].val - k;
				step.position   = SCRIPT[i].pos;
				offer(step, SCRIPT[i].typed, SCRIPT[i].want);
			end
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				choke_pending = 1'b1;
				tx_burst_left = 40;
			end
			offer(draw_action(), 1'b0, '0);
		end
		req_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : result_side
		rsp_t want;
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			if (choke_pending) begin
				choke_pending = 1'b0;
				hold = CHOKE_CYCLES;
			end else if (rx_burst_left > 0) begin
				rx_burst_left--;
				hold = 0;
			end else begin
				hold = $urandom_range(0, MAX_WAIT);
				if ($urandom_range(0, 39) == 0) begin
					rx_burst_left = 30;
				end
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (due_results.size() == 0) begin
				note_mismatch("result with nothing pending", rsp, '0);
			end else begin
				want = due_results.pop_front();
				if (rsp.status !== want.status) begin
					note_mismatch("status", rsp.status, want.status);
				end
				if (rsp.result_value !== want.result_value) begin
					note_mismatch("result_value", rsp.result_value, want.result_value);
				end
				if (rsp.found_position !== want.found_position) begin
					note_mismatch("found_position", rsp.found_position, want.found_position);
				end
				if (rsp.entry_count !== want.entry_count) begin
					note_mismatch("entry_count", rsp.entry_count, want.entry_count);
				end
			end
		end
	end

endmodule
